// ----- rtl/pac_pkg.sv -----
// ----------------------------------------------------------------------------
// pac_pkg
// shared types and constants of the proximity alarm controller
// ----------------------------------------------------------------------------
package pac_pkg;

    localparam int ECHO_W   = 16;
    localparam int DIST_W   = 13;
    localparam int CM_W     = 9;
    localparam int MS_W     = 16;
    localparam int WPER_W   = 11;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOCK_DIST   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WARN_DIST   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ERR_BLINK   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TRIG_PERIOD = 3'd5;

    // register reset values
    localparam logic [CM_W-1:0] LOCK_DIST_RST   = 9'd10;
    localparam logic [CM_W-1:0] WARN_DIST_RST   = 9'd50;
    localparam logic [CM_W-1:0] MAX_RANGE_RST   = 9'd400;
    localparam logic [MS_W-1:0] ERR_BLINK_RST   = 16'd300;
    localparam logic [MS_W-1:0] DEBOUNCE_RST    = 16'd50;
    localparam logic [MS_W-1:0] TRIG_PERIOD_RST = 16'd60;

    // state reset values
    localparam logic [DIST_W-1:0] FILT_RST = 13'd6400;
    localparam logic [WPER_W-1:0] WPER_RST = 11'd500;

    // echo microseconds per cm of distance
    localparam logic [ECHO_W-1:0] ECHO_US_PER_CM = 16'd58;

    // floor(x / 29) = (x * RAW_RECIP) >> RAW_SHIFT, exact for x below 2^20
    localparam int              RAW_PROD_W = 39;
    localparam logic [19:0]     RAW_RECIP  = 20'd578525;
    localparam int              RAW_SHIFT  = 24;

    // floor(x / 5) = (x * FILT_RECIP) >> FILT_SHIFT, exact for x below 2^18
    localparam int              FILT_SUM_W  = 16;
    localparam logic [15:0]     FILT_RECIP  = 16'd52429;
    localparam int              FILT_SHIFT  = 18;

    typedef struct packed {
        logic [DIST_W-1:0] raw;
        logic              in_range;
    } echo_conv_t;

endpackage

// ----- rtl/pac_tick_if.sv -----
// ----------------------------------------------------------------------------
// pac_tick_if
// input channel: one transaction per millisecond tick
// ----------------------------------------------------------------------------
interface pac_tick_if;
    import pac_pkg::*;

    logic              valid;
    logic              ready;
    logic              echo_valid;
    logic [ECHO_W-1:0] echo_micros;
    logic              button_level;

    modport source (output valid, output echo_valid, output echo_micros,
                    output button_level, input ready);
    modport sink   (input valid, input echo_valid, input echo_micros,
                    input button_level, output ready);
endinterface

// ----- rtl/pac_result_if.sv -----
// ----------------------------------------------------------------------------
// pac_result_if
// output channel: one result transaction per tick
// ----------------------------------------------------------------------------
interface pac_result_if;
    import pac_pkg::*;

    logic              valid;
    logic              ready;
    logic              trigger_pulse;
    logic              warning_led;
    logic              error_led;
    logic              locked;
    logic [DIST_W-1:0] distance_sixteenths;
    logic              distance_updated;
    logic              warning_zone;

    modport source (output valid, output trigger_pulse, output warning_led,
                    output error_led, output locked, output distance_sixteenths,
                    output distance_updated, output warning_zone, input ready);
    modport sink   (input valid, input trigger_pulse, input warning_led,
                    input error_led, input locked, input distance_sixteenths,
                    input distance_updated, input warning_zone, output ready);
endinterface

// ----- rtl/proximity_alarm_controller.sv -----
// ----------------------------------------------------------------------------
// proximity_alarm_controller
// ultrasonic distance filter, lock logic, blink timers and trigger timer
//
//  channel  | dir | transaction
//  ---------+-----+----------------------------------------------------------
//  tick     | in  | one ms tick: echo_valid, echo_micros, button_level
//  result   | out | trigger, leds, lock, filtered distance, update, zone
//  cfg      | in  | register write: cfg_we, cfg_index, cfg_wdata
//
//  one transaction per clock cycle sustained while result is ready; each
//  tick passes an input register, a register after the echo multiplier,
//  then the state update and the result register
//  the state loop runs combinationally through the divide-by-five multiplier
//  reset clears all timers and levels, distance 6400, blink period 500
//  a stalled result holds the pipeline; ready drops only when it is full
// ----------------------------------------------------------------------------
module proximity_alarm_controller
(
    input  logic                            clk,
    input  logic                            rst_n,
    pac_tick_if.sink                        tick,
    pac_result_if.source                    result,
    input  logic                            cfg_we,
    input  logic [pac_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pac_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import pac_pkg::*;

    function automatic logic [MS_W-1:0] sat_inc(input logic [MS_W-1:0] v);
        sat_inc = (v == {MS_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    // configuration
    logic [CM_W-1:0] lock_dist_reg;
    logic [CM_W-1:0] warn_dist_reg;
    logic [CM_W-1:0] max_range_reg;
    logic [MS_W-1:0] err_blink_reg;
    logic [MS_W-1:0] debounce_reg;
    logic [MS_W-1:0] trig_period_reg;

    // pipeline
    logic              a_v_reg;
    logic              a_echo_valid_reg;
    logic [ECHO_W-1:0] a_echo_micros_reg;
    logic              a_button_reg;
    echo_conv_t        a_conv;

    logic              b_v_reg;
    logic              b_echo_valid_reg;
    logic [DIST_W-1:0] b_raw_reg;
    logic              b_in_range_reg;
    logic              b_button_reg;

    logic              o_v_reg;
    logic              o_trig_reg;
    logic              o_wled_reg;
    logic              o_eled_reg;
    logic              o_locked_reg;
    logic [DIST_W-1:0] o_dist_reg;
    logic              o_upd_reg;
    logic              o_zone_reg;

    logic out_adv;
    logic b_adv;
    logic a_adv;
    logic step;

    // state
    logic [DIST_W-1:0] filt_reg,    filt_next;
    logic [WPER_W-1:0] wper_reg,    wper_next;
    logic [MS_W-1:0]   warn_el_reg, warn_el_next;
    logic [MS_W-1:0]   err_el_reg,  err_el_next;
    logic [MS_W-1:0]   btn_el_reg,  btn_el_next;
    logic [MS_W-1:0]   trig_el_reg, trig_el_next;
    logic              lock_reg,    lock_next;
    logic              wl_reg,      wl_next;
    logic              el_reg,      el_next;
    logic              stored_reg,  stored_next;
    logic              trig_next;
    logic              zone_next;

    logic [FILT_SUM_W-1:0] filt_sum;
    logic [31:0]           filt_prod;
    logic [DIST_W-1:0]     filt_quot;

    assign out_adv    = !o_v_reg || result.ready;
    assign b_adv      = !b_v_reg || out_adv;
    assign a_adv      = !a_v_reg || b_adv;
    assign tick.ready = a_adv;
    assign step       = b_v_reg && out_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lock_dist_reg   <= LOCK_DIST_RST;
            warn_dist_reg   <= WARN_DIST_RST;
            max_range_reg   <= MAX_RANGE_RST;
            err_blink_reg   <= ERR_BLINK_RST;
            debounce_reg    <= DEBOUNCE_RST;
            trig_period_reg <= TRIG_PERIOD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LOCK_DIST:   lock_dist_reg   <= cfg_wdata[CM_W-1:0];
                REG_WARN_DIST:   warn_dist_reg   <= cfg_wdata[CM_W-1:0];
                REG_MAX_RANGE:   max_range_reg   <= cfg_wdata[CM_W-1:0];
                REG_ERR_BLINK:   err_blink_reg   <= cfg_wdata[MS_W-1:0];
                REG_DEBOUNCE:    debounce_reg    <= cfg_wdata[MS_W-1:0];
                REG_TRIG_PERIOD: trig_period_reg <= cfg_wdata[MS_W-1:0];
                default:         ;
            endcase
        end
    end

    pac_echo_conv u_echo_conv
    (
        .echo_micros  (a_echo_micros_reg),
        .max_range_cm (max_range_reg),
        .conv         (a_conv)
    );

    // pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end
        else
        begin
            if (a_adv)
                a_v_reg <= tick.valid;
            if (b_adv)
                b_v_reg <= a_v_reg;
            if (out_adv)
                o_v_reg <= b_v_reg;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (a_adv && tick.valid)
        begin
            a_echo_valid_reg  <= tick.echo_valid;
            a_echo_micros_reg <= tick.echo_micros;
            a_button_reg      <= tick.button_level;
        end
        if (b_adv && a_v_reg)
        begin
            b_echo_valid_reg <= a_echo_valid_reg;
            b_raw_reg        <= a_conv.raw;
            b_in_range_reg   <= a_conv.in_range;
            b_button_reg     <= a_button_reg;
        end
        if (step)
        begin
            o_trig_reg   <= trig_next;
            o_wled_reg   <= wl_next;
            o_eled_reg   <= el_next;
            o_locked_reg <= lock_next;
            o_dist_reg   <= filt_next;
            o_upd_reg    <= b_echo_valid_reg;
            o_zone_reg   <= zone_next;
        end
    end

    // 3:2 smoothing, sum divided by five
    assign filt_sum  = FILT_SUM_W'(filt_reg) + FILT_SUM_W'({filt_reg, 1'b0})
                     + FILT_SUM_W'({b_raw_reg, 1'b0});
    assign filt_prod = 32'(filt_sum) * 32'(FILT_RECIP);
    assign filt_quot = filt_prod[FILT_SHIFT +: DIST_W];

    always_comb
    begin
        warn_el_next = sat_inc(warn_el_reg);
        err_el_next  = sat_inc(err_el_reg);
        btn_el_next  = sat_inc(btn_el_reg);
        trig_el_next = sat_inc(trig_el_reg);
        lock_next    = lock_reg;
        wl_next      = wl_reg;
        el_next      = el_reg;
        stored_next  = stored_reg;
        filt_next    = filt_reg;
        wper_next    = wper_reg;
        trig_next    = 1'b0;

        if (lock_reg)
        begin
            if (err_el_next > err_blink_reg)
            begin
                err_el_next = err_el_next - err_blink_reg;
                el_next     = !el_next;
                wl_next     = !wl_next;
            end
            if (btn_el_next > debounce_reg && b_button_reg != stored_reg)
            begin
                btn_el_next = '0;
                stored_next = b_button_reg;
                // release unlocks
                if (!b_button_reg)
                begin
                    lock_next = 1'b0;
                    el_next   = 1'b0;
                end
            end
        end
        else if (warn_el_next > MS_W'(wper_reg))
        begin
            warn_el_next = warn_el_next - MS_W'(wper_reg);
            wl_next      = !wl_next;
        end

        if (trig_el_next > trig_period_reg)
        begin
            trig_el_next = trig_el_next - trig_period_reg;
            trig_next    = 1'b1;
        end

        if (b_echo_valid_reg)
        begin
            if (b_in_range_reg)
                filt_next = filt_quot;
            wper_next = filt_next[DIST_W-1:2];
            if (filt_next < {lock_dist_reg, 4'b0000} && !lock_next)
            begin
                lock_next = 1'b1;
                wl_next   = 1'b0;
                el_next   = 1'b0;
            end
        end

        zone_next = (filt_next <= {warn_dist_reg, 4'b0000});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filt_reg    <= FILT_RST;
            wper_reg    <= WPER_RST;
            warn_el_reg <= '0;
            err_el_reg  <= '0;
            btn_el_reg  <= '0;
            trig_el_reg <= '0;
            lock_reg    <= 1'b0;
            wl_reg      <= 1'b0;
            el_reg      <= 1'b0;
            stored_reg  <= 1'b0;
        end
        else if (step)
        begin
            filt_reg    <= filt_next;
            wper_reg    <= wper_next;
            warn_el_reg <= warn_el_next;
            err_el_reg  <= err_el_next;
            btn_el_reg  <= btn_el_next;
            trig_el_reg <= trig_el_next;
            lock_reg    <= lock_next;
            wl_reg      <= wl_next;
            el_reg      <= el_next;
            stored_reg  <= stored_next;
        end
    end

    assign result.valid               = o_v_reg;
    assign result.trigger_pulse       = o_trig_reg;
    assign result.warning_led         = o_wled_reg;
    assign result.error_led           = o_eled_reg;
    assign result.locked              = o_locked_reg;
    assign result.distance_sixteenths = o_dist_reg;
    assign result.distance_updated    = o_upd_reg;
    assign result.warning_zone        = o_zone_reg;

    // both leds blink in phase while locked
    assert property (@(posedge clk) disable iff (!rst_n)
        lock_reg |-> (wl_reg == el_reg))
        else $error("led levels out of phase while locked");

    // error led is dark while unlocked
    assert property (@(posedge clk) disable iff (!rst_n)
        !lock_reg |-> !el_reg)
        else $error("error level set while unlocked");

    // filter state moves only on a tick that delivers an echo
    assert property (@(posedge clk) disable iff (!rst_n)
        !(step && b_echo_valid_reg) |=> $stable(filt_reg) && $stable(wper_reg))
        else $error("distance state changed without an echo");

endmodule

// ----- rtl/pac_echo_conv.sv -----
// ----------------------------------------------------------------------------
// pac_echo_conv
// echo width to raw distance in sixteenths of a cm, with range check
// ----------------------------------------------------------------------------
module pac_echo_conv
(
    input  logic [pac_pkg::ECHO_W-1:0] echo_micros,
    input  logic [pac_pkg::CM_W-1:0]   max_range_cm,
    output pac_pkg::echo_conv_t        conv
);
    import pac_pkg::*;

    logic [RAW_PROD_W-1:0] prod;
    logic [ECHO_W-1:0]     limit;

    // us * 16 / 58 = (us * 8) / 29
    assign prod  = RAW_PROD_W'({echo_micros, 3'b000}) * RAW_PROD_W'(RAW_RECIP);
    assign limit = ECHO_W'(max_range_cm) * ECHO_US_PER_CM;

    // in range the quotient stays below 2^13
    assign conv.raw      = prod[RAW_SHIFT +: DIST_W];
    assign conv.in_range = (echo_micros <= limit);
endmodule
